// ----- rtl/core/assert_macros.svh -----
// Assertion macros used by the evaluator top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every clock edge outside reset
`define PSEV_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// antecedent implies consequent in the same cycle
`define PSEV_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define PSEV_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/psev_pkg.sv -----
// Types and constants of the postfix stack evaluator
package psev_pkg;

  typedef enum logic [3:0] {
    OP_PUSH    = 4'd0,
    OP_ADD     = 4'd1,
    OP_SUB     = 4'd2,
    OP_MUL     = 4'd3,
    OP_XOR     = 4'd4,
    OP_ROTL    = 4'd5,
    OP_ROTR    = 4'd6,
    OP_SHL     = 4'd7,
    OP_SAR     = 4'd8,
    OP_AND     = 4'd9,
    OP_OR      = 4'd10,
    OP_NOT     = 4'd11,
    OP_INVALID = 4'd12
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_UNDER   = 2'd1,
    ST_OVER    = 2'd2,
    ST_INVALID = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_DONE
  } ctrl_state_e;

  typedef struct packed {
    logic [3:0]         operation;
    logic signed [31:0] operand_value;
    logic               last_token;
  } token_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic [1:0]         status;
  } result_t;

  typedef struct packed {
    logic    accept;
    logic    push;
    logic    rd;
    logic    exec;
    logic    negate;
    logic    set_err;
    status_e err_code;
    logic    finish;
  } psev_cmd_t;

  typedef struct packed {
    logic err;
    logic empty;
    logic lt2;
    logic full;
  } psev_sts_t;

endpackage

// ----- rtl/core/psev_ctrl.sv -----
// Token sequencer: decodes requests and steps the datapath
module psev_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  psev_pkg::token_t  token_i,
  input  psev_pkg::psev_sts_t sts_i,
  output logic              busy_o,
  output logic              done_o,
  output psev_pkg::psev_cmd_t cmd_o
);
  import psev_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        last_q, last_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      last_q  <= last_d;
    end
  end

  always_comb begin
    state_d = state_q;
    last_d  = last_q;
    cmd_o   = '0;
    cmd_o.err_code = ST_OK;
    busy_o  = (state_q != S_IDLE);
    done_o  = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.accept = 1'b1;
          last_d  = token_i.last_token;
          state_d = token_i.last_token ? S_DONE : S_IDLE;
          if (!sts_i.err) begin
            case (token_i.operation)
              OP_PUSH: begin
                if (sts_i.full) begin
                  cmd_o.set_err  = 1'b1;
                  cmd_o.err_code = ST_OVER;
                end else begin
                  cmd_o.push = 1'b1;
                end
              end
              OP_ADD, OP_SUB, OP_MUL, OP_XOR, OP_ROTL, OP_ROTR,
              OP_SHL, OP_SAR, OP_AND, OP_OR: begin
                if (sts_i.lt2) begin
                  cmd_o.set_err  = 1'b1;
                  cmd_o.err_code = ST_UNDER;
                end else begin
                  cmd_o.rd = 1'b1;
                  state_d  = S_EXEC;
                end
              end
              OP_NOT: begin
                if (sts_i.empty) begin
                  cmd_o.set_err  = 1'b1;
                  cmd_o.err_code = ST_UNDER;
                end else begin
                  cmd_o.negate = 1'b1;
                end
              end
              default: begin
                cmd_o.set_err  = 1'b1;
                cmd_o.err_code = ST_INVALID;
              end
            endcase
          end
        end
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = last_q ? S_DONE : S_IDLE;
      end
      S_DONE: begin
        done_o       = 1'b1;
        cmd_o.finish = 1'b1;
        state_d      = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/core/psev_datapath.sv -----
// Operand stack, top register, ALU and sticky error
module psev_datapath #(
  parameter int unsigned STACK_DEPTH = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  psev_pkg::token_t    token_i,
  input  psev_pkg::psev_cmd_t cmd_i,
  output psev_pkg::psev_sts_t sts_o,
  output psev_pkg::result_t   result_o
);
  import psev_pkg::*;

  localparam int unsigned AW = $clog2(STACK_DEPTH);
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

  logic [31:0]   mem_q [STACK_DEPTH];
  logic [31:0]   rd_q;
  logic [31:0]   top_q, top_d;
  logic [3:0]    op_q;
  logic [CW-1:0] count_q, count_d;
  status_e       err_q, err_d;
  logic [CW-1:0] wr_idx, rd_idx;
  logic [31:0]   alu_y;
  status_e       fin_status;

  function automatic logic [31:0] alu(input logic [3:0] op, input logic [31:0] a,
                                      input logic [31:0] b);
    logic [4:0]  s;
    logic        big;
    logic [31:0] y;
    s   = b[4:0];
    big = |b[31:5];
    case (op)
      OP_ADD:  y = a + b;
      OP_SUB:  y = a - b;
      OP_MUL:  y = a * b;
      OP_XOR:  y = a ^ b;
      OP_ROTL: y = (a << s) | (a >> (6'd32 - {1'b0, s}));
      OP_ROTR: y = (a >> s) | (a << (6'd32 - {1'b0, s}));
      OP_SHL:  y = big ? 32'd0 : (a << s);
      OP_SAR:  y = big ? {32{a[31]}} : 32'($signed(a) >>> s);
      OP_AND:  y = a & b;
      default: y = a | b;
    endcase
    return y;
  endfunction

  assign wr_idx = count_q - CW'(1);
  assign rd_idx = count_q - CW'(2);
  assign alu_y  = alu(op_q, rd_q, top_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.push && (count_q != '0)) begin
      mem_q[wr_idx[AW-1:0]] <= top_q;
    end
    if (cmd_i.rd) begin
      rd_q <= mem_q[rd_idx[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    top_q <= top_d;
    if (cmd_i.accept) begin
      op_q <= token_i.operation;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      err_q   <= ST_OK;
    end else begin
      count_q <= count_d;
      err_q   <= err_d;
    end
  end

  always_comb begin
    top_d   = top_q;
    count_d = count_q;
    err_d   = err_q;
    if (cmd_i.push) begin
      top_d   = token_i.operand_value;
      count_d = count_q + CW'(1);
    end
    if (cmd_i.negate) begin
      top_d = ~top_q;
    end
    if (cmd_i.exec) begin
      top_d   = alu_y;
      count_d = count_q - CW'(1);
    end
    if (cmd_i.set_err) begin
      err_d = cmd_i.err_code;
    end
    if (cmd_i.finish) begin
      count_d = '0;
      err_d   = ST_OK;
    end
  end

  assign sts_o.err   = (err_q != ST_OK);
  assign sts_o.empty = (count_q == '0);
  assign sts_o.lt2   = (count_q < CW'(2));
  assign sts_o.full  = (count_q == CW'(STACK_DEPTH));

  always_comb begin
    if (err_q != ST_OK) begin
      fin_status = err_q;
    end else if (count_q == '0) begin
      fin_status = ST_UNDER;
    end else begin
      fin_status = ST_OK;
    end
  end

  assign result_o.status       = fin_status;
  assign result_o.result_value = (fin_status == ST_OK) ? top_q : 32'sd0;

endmodule

// ----- rtl/core/postfix_stack_evaluator.sv -----
// Postfix stack evaluator top level
// Push, not and error tokens complete in S_IDLE; binary operators also pass through
// S_EXEC after the registered stack read. A last token adds S_DONE, in which the
// result strobe is high. No new token is taken while busy in S_EXEC or S_DONE.
// Reset clears the controller, stack count and error; stack entries stay unset.
// Results are strobed for one cycle and cannot be stalled by the receiver.
module postfix_stack_evaluator #(
  parameter int unsigned STACK_DEPTH = 256
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  psev_pkg::token_t  token_i,
  output logic              busy,
  output logic              result_valid_o,
  output psev_pkg::result_t result_o
);
  import psev_pkg::*;
  `include "assert_macros.svh"

  psev_cmd_t cmd;
  psev_sts_t sts;
  logic      ctrl_busy;
  logic      req_accept;

  psev_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .token_i (token_i),
    .sts_i   (sts),
    .busy_o  (ctrl_busy),
    .done_o  (result_valid_o),
    .cmd_o   (cmd)
  );

  psev_datapath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .token_i  (token_i),
    .cmd_i    (cmd),
    .sts_o    (sts),
    .result_o (result_o)
  );

  assign busy       = ctrl_busy;
  assign req_accept = start && !ctrl_busy;

  `PSEV_ASSERT_NEXT(a_single_strobe, result_valid_o, !result_valid_o, "result strobe repeated")
  `PSEV_ASSERT_IMPL(a_err_zero, result_valid_o && (result_o.status != ST_OK),
                    result_o.result_value == 32'sd0, "nonzero result on error")
  `PSEV_ASSERT_NEXT(a_last_busy, req_accept && token_i.last_token, busy,
                    "last request did not hold busy")
  `PSEV_ASSERT(a_strobe_busy, !result_valid_o || busy, "result strobe while idle")

endmodule
